// File: rtl/mc16_pkg.sv
// ----------------------------------------------------------------------------
// mc16_pkg
// types and codes shared by the 16-bit multicycle processor
// ----------------------------------------------------------------------------
package mc16_pkg;

  typedef enum logic [3:0] {
    ST_FETCH   = 4'd0,
    ST_DECODE  = 4'd1,
    ST_ADDR    = 4'd2,
    ST_MEM_RD  = 4'd3,
    ST_LD_WB   = 4'd4,
    ST_MEM_WR  = 4'd5,
    ST_ADDI_WB = 4'd6,
    ST_R_EXEC  = 4'd7,
    ST_R_WB    = 4'd8,
    ST_BEQ     = 4'd9,
    ST_JUMP    = 4'd10
  } state_t;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_STEP = 2'd1,
    OP_READ = 2'd2,
    OP_NONE = 2'd3
  } oper_t;

  typedef enum logic [2:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_AND,
    ALU_OR,
    ALU_ZERO
  } alu_op_t;

  localparam logic [3:0] OPC_RTYPE = 4'd0;
  localparam logic [3:0] OPC_J     = 4'd2;
  localparam logic [3:0] OPC_ADDI  = 4'd4;
  localparam logic [3:0] OPC_BEQ   = 4'd8;
  localparam logic [3:0] OPC_LW    = 4'd11;
  localparam logic [3:0] OPC_SW    = 4'd15;

  localparam logic [2:0] FN_ADD = 3'd0;
  localparam logic [2:0] FN_SUB = 3'd2;
  localparam logic [2:0] FN_AND = 3'd4;
  localparam logic [2:0] FN_OR  = 3'd5;

  localparam int OVF_HI = 256;
  localparam int OVF_LO = -128;

  localparam int PC_W   = 8;
  localparam int WORD_W = 16;
  localparam int RIDX_W = 3;

endpackage

// File: rtl/mc16_if.sv
// ----------------------------------------------------------------------------
// mc16 channel interfaces
// valid/ready channels for load, step and read transactions and their results
// ----------------------------------------------------------------------------
interface mc16_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  operation;
  logic [7:0]  address;
  logic [15:0] word;

  modport source (output valid, operation, address, word, input ready);
  modport sink (input valid, operation, address, word, output ready);
endinterface

interface mc16_out_if #(parameter int DW = 16);
  logic          valid;
  logic          ready;
  logic [3:0]    control_state;
  logic [7:0]    program_counter;
  logic          reg_written;
  logic [2:0]    reg_index;
  logic [DW-1:0] reg_value;
  logic          mem_written;
  logic          overflow;
  logic          branch_taken;

  modport source (output valid, control_state, program_counter, reg_written, reg_index,
                  reg_value, mem_written, overflow, branch_taken, input ready);
  modport sink (input valid, control_state, program_counter, reg_written, reg_index,
                reg_value, mem_written, overflow, branch_taken, output ready);
endinterface

// File: rtl/mc16_ram.sv
// ----------------------------------------------------------------------------
// mc16_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module mc16_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/multicycle_cpu_16bit.sv
// an accepted transaction is registered in the execute stage, its result at commit
// throughput: one transaction per cycle unless the output stalls; the ram read in the
//   accept cycle overlaps the prior read-modify-write, with write-to-read forwarding
// reset: synchronous active-low rst_n clears pc, instruction, alu and state registers
//   and the register valid bits; main memory content is not cleared
// MEM_DEPTH must be a power of two
// ----------------------------------------------------------------------------
// multicycle_cpu_16bit
// multicycle processor stepped one control state per transaction
// ----------------------------------------------------------------------------
module multicycle_cpu_16bit #(
  parameter int MEM_DEPTH  = 256,
  parameter int NUM_REGS   = 8,
  parameter int DATA_WIDTH = 16
) (
  input logic               clk,
  input logic               rst_n,
  mc16_in_if.sink           in_chan,
  mc16_out_if.source        out_chan
);

  localparam int DW = DATA_WIDTH;
  localparam int AW = $clog2(MEM_DEPTH);
  localparam int OW = (DW + 1 > 10) ? DW + 1 : 10;
  localparam int RW = mc16_pkg::RIDX_W;
  localparam int PW = mc16_pkg::PC_W;
  localparam int WW = mc16_pkg::WORD_W;
  localparam logic signed [OW-1:0] OVF_HI = OW'(mc16_pkg::OVF_HI);
  localparam logic signed [OW-1:0] OVF_LO = OW'(mc16_pkg::OVF_LO);

  // architectural state
  mc16_pkg::state_t state_r, state_nxt;
  logic [PW-1:0]    pc_r, pc_nxt;
  logic [WW-1:0]    ir_r, ir_nxt;
  logic [DW-1:0]    alu_r, alu_nxt;
  logic             ovf_r, ovf_nxt;
  logic [WW-1:0]    mdr_r, mdr_nxt;
  logic [NUM_REGS-1:0] rf_vld_r;

  // execute stage
  logic             s1_valid_r;
  logic [1:0]       s1_op_r;
  logic [7:0]       s1_addr_r;
  logic [WW-1:0]    s1_word_r;
  logic             accept, commit;

  // ram ports
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [WW-1:0] mem_wdata, mem_dout, mem_rd;
  logic          rf_we;
  logic [RW-1:0] rf_waddr, rfa_raddr, rfb_raddr;
  logic [DW-1:0] rf_wdata, rfa_dout, rfb_dout, rfa_rd, rfb_rd;

  // forwarding
  logic          mem_hit_r, rfa_hit_r, rfb_hit_r;
  logic [WW-1:0] mem_fwd_r;
  logic [DW-1:0] rfa_fwd_r, rfb_fwd_r;
  logic          rfa_vld_r, rfb_vld_r;

  // alu
  mc16_pkg::alu_op_t alu_op;
  logic              alu_en;
  logic [DW-1:0]     alu_a, alu_b, alu_res;
  logic              alu_ovf;
  logic signed [OW-1:0] alu_sa, alu_sb, alu_wide;

  // result
  logic          out_valid_r;
  logic [3:0]    o_state_r;
  logic [PW-1:0] o_pc_r;
  logic          o_wr_r, o_wr;
  logic [RW-1:0] o_idx_r, o_idx;
  logic [DW-1:0] o_val_r, o_val;
  logic          o_mw_r, o_mw, o_ovf_r, o_ovf, o_br_r, o_br;

  logic [3:0]    opc;
  logic [RW-1:0] rs, rt, rd;
  logic [2:0]    funct;
  logic [DW-1:0] simm, uimm;

  assign opc   = ir_r[15:12];
  assign rs    = ir_r[11:9];
  assign rt    = ir_r[8:6];
  assign rd    = ir_r[5:3];
  assign funct = ir_r[2:0];
  assign simm  = {{(DW-6){ir_r[5]}}, ir_r[5:0]};
  assign uimm  = DW'(ir_r[5:0]);

  assign commit       = s1_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_valid_r || commit;
  assign accept       = in_chan.valid && in_chan.ready;

  assign mem_rd = mem_hit_r ? mem_fwd_r : mem_dout;
  assign rfa_rd = rfa_hit_r ? rfa_fwd_r : (rfa_vld_r ? rfa_dout : '0);
  assign rfb_rd = rfb_hit_r ? rfb_fwd_r : (rfb_vld_r ? rfb_dout : '0);

  // alu
  always_comb begin
    alu_sa   = {{(OW-DW){alu_a[DW-1]}}, alu_a};
    alu_sb   = {{(OW-DW){alu_b[DW-1]}}, alu_b};
    alu_wide = '0;
    case (alu_op)
      mc16_pkg::ALU_ADD: alu_wide = alu_sa + alu_sb;
      mc16_pkg::ALU_SUB: alu_wide = alu_sa - alu_sb;
      mc16_pkg::ALU_AND: alu_wide = alu_sa & alu_sb;
      mc16_pkg::ALU_OR:  alu_wide = alu_sa | alu_sb;
      default:           alu_wide = '0;
    endcase
    alu_res = alu_wide[DW-1:0];
    alu_ovf = (alu_wide > OVF_HI) || (alu_wide < OVF_LO);
  end

  // execute: next state, write-back and result
  always_comb begin
    state_nxt = state_r;
    pc_nxt    = pc_r;
    ir_nxt    = ir_r;
    alu_nxt   = alu_r;
    ovf_nxt   = ovf_r;
    mdr_nxt   = mdr_r;
    alu_en    = 1'b0;
    alu_op    = mc16_pkg::ALU_ADD;
    alu_a     = DW'(pc_r);
    alu_b     = '0;
    mem_we    = 1'b0;
    mem_waddr = AW'(s1_addr_r);
    mem_wdata = s1_word_r;
    rf_we     = 1'b0;
    rf_waddr  = rt;
    rf_wdata  = alu_r;
    o_wr      = 1'b0;
    o_idx     = '0;
    o_val     = '0;
    o_mw      = 1'b0;
    o_ovf     = 1'b0;
    o_br      = 1'b0;
    if (commit) begin
      unique case (mc16_pkg::oper_t'(s1_op_r))
        mc16_pkg::OP_LOAD: begin
          mem_we = 1'b1;
        end
        mc16_pkg::OP_READ: begin
          o_idx = s1_addr_r[RW-1:0];
          o_val = rfa_rd;
        end
        mc16_pkg::OP_STEP: begin
          unique case (state_r)
            mc16_pkg::ST_FETCH: begin
              ir_nxt    = mem_rd;
              pc_nxt    = pc_r + PW'(1);
              alu_en    = 1'b1;
              alu_b     = DW'(1);
              state_nxt = mc16_pkg::ST_DECODE;
            end
            mc16_pkg::ST_DECODE: begin
              if (ir_r == '0) begin
                state_nxt = mc16_pkg::ST_FETCH;
              end else begin
                alu_en = 1'b1;
                unique case (opc)
                  mc16_pkg::OPC_RTYPE: state_nxt = mc16_pkg::ST_R_EXEC;
                  mc16_pkg::OPC_J:     state_nxt = mc16_pkg::ST_JUMP;
                  mc16_pkg::OPC_BEQ: begin
                    state_nxt = mc16_pkg::ST_BEQ;
                    alu_b     = uimm;
                  end
                  default: begin
                    state_nxt = mc16_pkg::ST_ADDR;
                    alu_b     = simm;
                  end
                endcase
              end
            end
            mc16_pkg::ST_ADDR: begin
              alu_en = 1'b1;
              alu_a  = rfa_rd;
              alu_b  = simm;
              unique case (opc)
                mc16_pkg::OPC_ADDI: state_nxt = mc16_pkg::ST_ADDI_WB;
                mc16_pkg::OPC_LW:   state_nxt = mc16_pkg::ST_MEM_RD;
                mc16_pkg::OPC_SW:   state_nxt = mc16_pkg::ST_MEM_WR;
                default:            state_nxt = mc16_pkg::ST_FETCH;
              endcase
            end
            mc16_pkg::ST_MEM_RD: begin
              mdr_nxt   = mem_rd;
              state_nxt = mc16_pkg::ST_LD_WB;
            end
            mc16_pkg::ST_LD_WB: begin
              rf_we     = 1'b1;
              rf_wdata  = DW'(mdr_r);
              o_wr      = 1'b1;
              o_idx     = rt;
              o_val     = DW'(mdr_r);
              state_nxt = mc16_pkg::ST_FETCH;
            end
            mc16_pkg::ST_MEM_WR: begin
              mem_we    = 1'b1;
              mem_waddr = AW'(alu_r);
              mem_wdata = WW'(rfb_rd);
              o_mw      = 1'b1;
              state_nxt = mc16_pkg::ST_FETCH;
            end
            mc16_pkg::ST_ADDI_WB: begin
              rf_we     = 1'b1;
              o_wr      = 1'b1;
              o_idx     = rt;
              o_val     = alu_r;
              o_ovf     = ovf_r;
              state_nxt = mc16_pkg::ST_FETCH;
            end
            mc16_pkg::ST_R_EXEC: begin
              alu_en = 1'b1;
              alu_a  = rfa_rd;
              alu_b  = rfb_rd;
              case (funct)
                mc16_pkg::FN_ADD: alu_op = mc16_pkg::ALU_ADD;
                mc16_pkg::FN_SUB: alu_op = mc16_pkg::ALU_SUB;
                mc16_pkg::FN_AND: alu_op = mc16_pkg::ALU_AND;
                mc16_pkg::FN_OR:  alu_op = mc16_pkg::ALU_OR;
                default:          alu_op = mc16_pkg::ALU_ZERO;
              endcase
              state_nxt = mc16_pkg::ST_R_WB;
            end
            mc16_pkg::ST_R_WB: begin
              rf_we     = 1'b1;
              rf_waddr  = rd;
              o_wr      = 1'b1;
              o_idx     = rd;
              o_val     = alu_r;
              o_ovf     = ovf_r;
              state_nxt = mc16_pkg::ST_FETCH;
            end
            mc16_pkg::ST_BEQ: begin
              alu_en = 1'b1;
              alu_op = mc16_pkg::ALU_SUB;
              alu_a  = rfa_rd;
              alu_b  = rfb_rd;
              if (alu_res == '0) begin
                pc_nxt = alu_r[PW-1:0];
                o_br   = 1'b1;
              end
              state_nxt = mc16_pkg::ST_FETCH;
            end
            mc16_pkg::ST_JUMP: begin
              pc_nxt    = ir_r[PW-1:0];
              state_nxt = mc16_pkg::ST_FETCH;
            end
            default: begin
              state_nxt = mc16_pkg::ST_FETCH;
            end
          endcase
        end
        default: begin
        end
      endcase
      if (alu_en) begin
        alu_nxt = alu_res;
        ovf_nxt = alu_ovf;
      end
    end
  end

  // read addresses for the incoming transaction, seen after the pending commit
  always_comb begin
    mem_raddr = (state_nxt == mc16_pkg::ST_MEM_RD) ? AW'(alu_nxt) : AW'(pc_nxt);
    rfa_raddr = (in_chan.operation == mc16_pkg::OP_READ) ? in_chan.address[RW-1:0]
                                                         : ir_nxt[11:9];
    rfb_raddr = ir_nxt[8:6];
  end

  mc16_ram #(.WIDTH(WW), .DEPTH(MEM_DEPTH)) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (accept),
    .raddr (mem_raddr),
    .rdata (mem_dout)
  );

  mc16_ram #(.WIDTH(DW), .DEPTH(NUM_REGS)) u_rf_a (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .re    (accept),
    .raddr (rfa_raddr),
    .rdata (rfa_dout)
  );

  mc16_ram #(.WIDTH(DW), .DEPTH(NUM_REGS)) u_rf_b (
    .clk   (clk),
    .we    (rf_we),
    .waddr (rf_waddr),
    .wdata (rf_wdata),
    .re    (accept),
    .raddr (rfb_raddr),
    .rdata (rfb_dout)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mc16_pkg::ST_FETCH;
      pc_r        <= '0;
      ir_r        <= '0;
      alu_r       <= '0;
      ovf_r       <= 1'b0;
      mdr_r       <= '0;
      rf_vld_r    <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pc_r    <= pc_nxt;
      ir_r    <= ir_nxt;
      alu_r   <= alu_nxt;
      ovf_r   <= ovf_nxt;
      mdr_r   <= mdr_nxt;
      if (rf_we) begin
        rf_vld_r[rf_waddr] <= 1'b1;
      end
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (commit) begin
        s1_valid_r <= 1'b0;
      end
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // transaction capture and forwarding
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r   <= in_chan.operation;
      s1_addr_r <= in_chan.address;
      s1_word_r <= in_chan.word;
      mem_hit_r <= mem_we && (mem_waddr == mem_raddr);
      mem_fwd_r <= mem_wdata;
      rfa_hit_r <= rf_we && (rf_waddr == rfa_raddr);
      rfb_hit_r <= rf_we && (rf_waddr == rfb_raddr);
      rfa_fwd_r <= rf_wdata;
      rfb_fwd_r <= rf_wdata;
      rfa_vld_r <= rf_vld_r[rfa_raddr];
      rfb_vld_r <= rf_vld_r[rfb_raddr];
    end
    if (commit) begin
      o_state_r <= state_nxt;
      o_pc_r    <= pc_nxt;
      o_wr_r    <= o_wr;
      o_idx_r   <= o_idx;
      o_val_r   <= o_val;
      o_mw_r    <= o_mw;
      o_ovf_r   <= o_ovf;
      o_br_r    <= o_br;
    end
  end

  assign out_chan.valid           = out_valid_r;
  assign out_chan.control_state   = o_state_r;
  assign out_chan.program_counter = o_pc_r;
  assign out_chan.reg_written     = o_wr_r;
  assign out_chan.reg_index       = o_idx_r;
  assign out_chan.reg_value       = o_val_r;
  assign out_chan.mem_written     = o_mw_r;
  assign out_chan.overflow        = o_ovf_r;
  assign out_chan.branch_taken    = o_br_r;

endmodule

// File: tb/sv/tb_multicycle_cpu_16bit.sv
// ----------------------------------------------------------------------------
// tb_multicycle_cpu_16bit
// self-checking testbench for the 16-bit multicycle processor: memory is
// preloaded with programs, then directed and random step, load and read
// transactions run against a cycle-level predictor with random idling
// on both channels and a long output hold-off
// ----------------------------------------------------------------------------
module tb_multicycle_cpu_16bit;
  import mc16_pkg::*;

  localparam int LIMIT = 200000;

  typedef struct packed {
    oper_t       op;
    logic [7:0]  addr;
    logic [15:0] word;
  } txn_t;

  typedef struct packed {
    logic [3:0]  st;
    logic [7:0]  pc;
    logic        wr;
    logic [2:0]  ridx;
    logic [15:0] rval;
    logic        mw;
    logic        ovf;
    logic        br;
  } res_t;

  logic clk;
  logic rst_n;

  mc16_in_if  in_chan ();
  mc16_out_if out_chan ();

  multicycle_cpu_16bit u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan.sink),
    .out_chan (out_chan.source)
  );

  txn_t pending[$];
  res_t expected_res[$];

  logic [15:0] mem_words[256];
  logic [15:0] regs[8];
  logic [7:0]  pc_q;
  logic [15:0] ir_q;
  logic [3:0]  st_q;
  logic [15:0] alu_res;
  logic        alu_ovf;
  logic [15:0] mdr_q;

  int errors = 0;
  int cycles = 0;
  int n_acc = 0;
  int n_seen = 0;
  int n_res = 0;
  int n_step = 0;
  int n_wr = 0;
  int n_ovf = 0;
  int n_br = 0;
  int n_mw = 0;
  int hold_left = 0;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic logic [15:0] enc_r(logic [2:0] rs, logic [2:0] rt, logic [2:0] rd,
                                        logic [2:0] fn);
    return {OPC_RTYPE, rs, rt, rd, fn};
  endfunction

  function automatic logic [15:0] enc_i(logic [3:0] opc, logic [2:0] rs, logic [2:0] rt,
                                        logic [5:0] imm);
    return {opc, rs, rt, imm};
  endfunction

  function automatic logic [15:0] rand_instr();
    logic [3:0] opc;
    logic [2:0] fn;
    int pick;
    pick = $urandom_range(0, 99);
    fn = 3'($urandom);
    if (pick < 30) return {OPC_RTYPE, 9'($urandom), ($urandom_range(0, 3) == 0) ? fn :
                           (pick < 8 ? FN_ADD : pick < 15 ? FN_SUB : pick < 22 ? FN_AND : FN_OR)};
    if (pick < 50) opc = OPC_ADDI;
    else if (pick < 62) opc = OPC_LW;
    else if (pick < 72) opc = OPC_SW;
    else if (pick < 84) opc = OPC_BEQ;
    else if (pick < 90) opc = OPC_J;
    else if (pick < 93) return 16'h0000;
    else opc = 4'($urandom);
    return {opc, 12'($urandom)};
  endfunction

  task automatic alu_calc(alu_op_t m, logic [15:0] a, logic [15:0] b);
    int sa;
    int sb;
    int r;
    sa = $signed(a);
    sb = $signed(b);
    case (m)
      ALU_ADD: r = sa + sb;
      ALU_SUB: r = sa - sb;
      ALU_AND: r = $signed(a & b);
      ALU_OR:  r = $signed(a | b);
      default: r = 0;
    endcase
    alu_ovf = (r > OVF_HI || r < OVF_LO);
    alu_res = r[15:0];
  endtask

  task automatic cpu_predict(txn_t t, output res_t e);
    logic [3:0]  opc;
    logic [2:0]  rs;
    logic [2:0]  rt;
    logic [2:0]  rd;
    logic [2:0]  fn;
    logic [15:0] imm6;
    logic [15:0] simm;
    logic [15:0] target;
    alu_op_t     m;
    opc = ir_q[15:12];
    rs = ir_q[11:9];
    rt = ir_q[8:6];
    rd = ir_q[5:3];
    fn = ir_q[2:0];
    imm6 = {10'd0, ir_q[5:0]};
    simm = {{10{ir_q[5]}}, ir_q[5:0]};
    e = '0;
    if (t.op == OP_LOAD) begin
      mem_words[t.addr] = t.word;
    end else if (t.op == OP_READ) begin
      e.ridx = t.addr[2:0];
      e.rval = regs[t.addr[2:0]];
    end else if (t.op == OP_STEP) begin
      n_step++;
      case (st_q)
        ST_FETCH: begin
          ir_q = mem_words[pc_q];
          alu_calc(ALU_ADD, {8'd0, pc_q}, 16'd1);
          pc_q = pc_q + 8'd1;
          st_q = ST_DECODE;
        end
        ST_DECODE: begin
          if (ir_q == 16'h0000) st_q = ST_FETCH;
          else if (opc == OPC_RTYPE) begin
            st_q = ST_R_EXEC;
            alu_calc(ALU_ADD, {8'd0, pc_q}, 16'd0);
          end else if (opc == OPC_J) begin
            st_q = ST_JUMP;
            alu_calc(ALU_ADD, {8'd0, pc_q}, 16'd0);
          end else if (opc == OPC_BEQ) begin
            st_q = ST_BEQ;
            alu_calc(ALU_ADD, {8'd0, pc_q}, imm6);
          end else begin
            st_q = ST_ADDR;
            alu_calc(ALU_ADD, {8'd0, pc_q}, simm);
          end
        end
        ST_ADDR: begin
          alu_calc(ALU_ADD, regs[rs], simm);
          if (opc == OPC_ADDI) st_q = ST_ADDI_WB;
          else if (opc == OPC_LW) st_q = ST_MEM_RD;
          else if (opc == OPC_SW) st_q = ST_MEM_WR;
          else st_q = ST_FETCH;
        end
        ST_MEM_RD: begin
          mdr_q = mem_words[alu_res[7:0]];
          st_q = ST_LD_WB;
        end
        ST_LD_WB: begin
          regs[rt] = mdr_q;
          e.wr = 1'b1;
          e.ridx = rt;
          e.rval = mdr_q;
          st_q = ST_FETCH;
        end
        ST_MEM_WR: begin
          mem_words[alu_res[7:0]] = regs[rt];
          e.mw = 1'b1;
          st_q = ST_FETCH;
        end
        ST_ADDI_WB: begin
          regs[rt] = alu_res;
          e.wr = 1'b1;
          e.ridx = rt;
          e.rval = alu_res;
          e.ovf = alu_ovf;
          st_q = ST_FETCH;
        end
        ST_R_EXEC: begin
          m = (fn == FN_ADD) ? ALU_ADD : (fn == FN_SUB) ? ALU_SUB :
              (fn == FN_AND) ? ALU_AND : (fn == FN_OR) ? ALU_OR : ALU_ZERO;
          alu_calc(m, regs[rs], regs[rt]);
          st_q = ST_R_WB;
        end
        ST_R_WB: begin
          regs[rd] = alu_res;
          e.wr = 1'b1;
          e.ridx = rd;
          e.rval = alu_res;
          e.ovf = alu_ovf;
          st_q = ST_FETCH;
        end
        ST_BEQ: begin
          target = alu_res;
          alu_calc(ALU_SUB, regs[rs], regs[rt]);
          if (alu_res == 16'd0) begin
            pc_q = target[7:0];
            e.br = 1'b1;
          end
          st_q = ST_FETCH;
        end
        ST_JUMP: begin
          pc_q = ir_q[7:0];
          st_q = ST_FETCH;
        end
        default: st_q = ST_FETCH;
      endcase
    end
    e.st = st_q;
    e.pc = pc_q;
  endtask

  task automatic report(string what, int got, int want);
    $display("mismatch at result %0d: %s got %0h expected %0h", n_res, what, got, want);
    errors++;
  endtask

  // accept, predict and check
  always @(posedge clk) begin
    res_t e;
    res_t g;
    txn_t t;
    cycles++;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("DONE: errors detected");
      $finish;
    end
    if (rst_n && out_chan.valid && out_chan.ready) begin
      g = '{out_chan.control_state, out_chan.program_counter, out_chan.reg_written,
            out_chan.reg_index, out_chan.reg_value, out_chan.mem_written,
            out_chan.overflow, out_chan.branch_taken};
      if (expected_res.size() == 0) begin
        $display("unexpected result transaction");
        errors++;
      end else begin
        e = expected_res.pop_front();
        if (g.st !== e.st) report("control_state", g.st, e.st);
        if (g.pc !== e.pc) report("program_counter", g.pc, e.pc);
        if (g.wr !== e.wr) report("reg_written", g.wr, e.wr);
        if (g.ridx !== e.ridx) report("reg_index", g.ridx, e.ridx);
        if (g.rval !== e.rval) report("reg_value", g.rval, e.rval);
        if (g.mw !== e.mw) report("mem_written", g.mw, e.mw);
        if (g.ovf !== e.ovf) report("overflow", g.ovf, e.ovf);
        if (g.br !== e.br) report("branch_taken", g.br, e.br);
        n_wr += e.wr;
        n_ovf += e.ovf;
        n_br += e.br;
        n_mw += e.mw;
      end
      n_res++;
    end
    if (rst_n && in_chan.valid && in_chan.ready) begin
      t = '{oper_t'(in_chan.operation), in_chan.address, in_chan.word};
      cpu_predict(t, e);
      expected_res.push_back(e);
      void'(pending.pop_front());
      n_acc++;
    end
  end

  // input driver
  always @(negedge clk) begin
    logic done;
    logic idle;
    done = (n_acc != n_seen);
    n_seen = n_acc;
    idle = !(cycles >= 1200 && cycles < 1500) && ($urandom_range(0, 99) < 31);
    if (!in_chan.valid || done) begin
      if (pending.size() > 0 && !idle) begin
        in_chan.valid     <= 1'b1;
        in_chan.operation <= pending[0].op;
        in_chan.address   <= pending[0].addr;
        in_chan.word      <= pending[0].word;
      end else begin
        in_chan.valid <= 1'b0;
      end
    end
  end

  // output ready with a long hold-off
  always @(negedge clk) begin
    if (cycles == 500) hold_left = 400;
    if (hold_left > 0) begin
      hold_left--;
      out_chan.ready <= 1'b0;
    end else if (cycles >= 1200 && cycles < 1500) begin
      out_chan.ready <= 1'b1;
    end else begin
      out_chan.ready <= ($urandom_range(0, 99) >= 31);
    end
  end

  task automatic add_txn(oper_t op, logic [7:0] addr, logic [15:0] word);
    pending.push_back('{op, addr, word});
  endtask

  initial begin
    logic [15:0] prog[16];
    int pick;
    in_chan.valid = 1'b0;
    in_chan.operation = OP_LOAD;
    in_chan.address = '0;
    in_chan.word = '0;
    out_chan.ready = 1'b0;
    regs = '{default: 16'd0};
    mem_words = '{default: 16'd0};
    pc_q = '0;
    ir_q = '0;
    st_q = ST_FETCH;
    alu_res = '0;
    alu_ovf = 1'b0;
    mdr_q = '0;
    rst_n = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    prog[0]  = enc_i(OPC_ADDI, 3'd0, 3'd1, 6'h1f);
    prog[1]  = enc_i(OPC_ADDI, 3'd0, 3'd2, 6'h20);
    prog[2]  = enc_r(3'd1, 3'd2, 3'd3, FN_ADD);
    prog[3]  = enc_r(3'd1, 3'd2, 3'd4, FN_SUB);
    prog[4]  = enc_r(3'd1, 3'd2, 3'd5, FN_AND);
    prog[5]  = enc_r(3'd1, 3'd2, 3'd6, FN_OR);
    prog[6]  = enc_r(3'd1, 3'd2, 3'd7, 3'd1);
    prog[7]  = enc_i(OPC_SW, 3'd0, 3'd1, 6'd40);
    prog[8]  = enc_i(OPC_LW, 3'd0, 3'd3, 6'd40);
    prog[9]  = enc_i(OPC_BEQ, 3'd1, 3'd3, 6'd2);
    prog[10] = 16'hffff;
    prog[11] = 16'hffff;
    prog[12] = 16'h0000;
    prog[13] = enc_i(4'd1, 3'd7, 3'd7, 6'h3f);
    prog[14] = {OPC_J, 12'hf10};
    prog[15] = 16'h0000;
    // fill every word so no fetch or load ever sees unwritten memory
    for (int a = 0; a < 256; a++)
      add_txn(OP_LOAD, 8'(a), (a < 16) ? prog[a] : ($urandom_range(0, 4) == 0 ?
              16'($urandom) : rand_instr()));
    add_txn(OP_LOAD, 8'hff, 16'hffff);
    add_txn(OP_LOAD, 8'h00, prog[0]);
    for (int i = 0; i < 48; i++) add_txn(OP_STEP, 8'($urandom), 16'($urandom));
    add_txn(OP_NONE, 8'hff, 16'hffff);
    for (int r = 0; r < 8; r++) add_txn(OP_READ, 8'(r), 16'h0);
    add_txn(OP_READ, 8'hff, 16'h0);

    for (int i = 0; i < 640; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 62) add_txn(OP_STEP, 8'($urandom), 16'($urandom));
      else if (pick < 82) add_txn(OP_LOAD, 8'($urandom),
                                  $urandom_range(0, 1) ? rand_instr() : 16'($urandom));
      else if (pick < 95) add_txn(OP_READ, 8'($urandom), 16'($urandom));
      else add_txn(OP_NONE, 8'($urandom), 16'($urandom));
    end

    wait (pending.size() == 0 && expected_res.size() == 0);
    repeat (10) @(posedge clk);
    $display("ran %0d transactions, %0d steps, %0d register writes, %0d stores", n_acc,
             n_step, n_wr, n_mw);
    $display("saw %0d overflows and %0d taken branches in %0d cycles", n_ovf, n_br, cycles);
    if (errors == 0 && expected_res.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
